// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== src/rfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfrc_pkg
// Shared types, codes and the CRC-16 byte update of the frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rfrc_pkg;

    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_ID     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BROADCAST_ID = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_MASK     = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_COPY     = 8'd3;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_TOO_SHORT  = 3'd1;
    localparam logic [2:0] STATUS_WRONG_ADDR = 3'd2;
    localparam logic [2:0] STATUS_LEN_ERR    = 3'd3;
    localparam logic [2:0] STATUS_CRC_ERR    = 3'd4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic [8:0] IDX_DEST  = 9'd0;
    localparam logic [8:0] IDX_SRC   = 9'd1;
    localparam logic [8:0] IDX_SEQ   = 9'd2;
    localparam logic [8:0] IDX_FLAGS = 9'd3;
    localparam logic [8:0] IDX_LEN   = 9'd4;
    localparam logic [8:0] HDR_LEN   = 9'd5;
    localparam logic [8:0] MIN_FRAME = 9'd7;
    localparam logic [8:0] COUNT_MAX = 9'd511;

    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] local_id;
        logic [7:0] broadcast_id;
        logic [7:0] ack_request_mask;
        logic [7:0] max_copy_len;
    } cfg_regs_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [2:0] status;
        logic [7:0] source_id;
        logic [7:0] sequence_res;
        logic [7:0] payload_length;
        logic       ack_owed;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        int          k;
        c = crc_in ^ {b, 8'h00};
        for (k = 0; k < 8; k++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
            begin
                c = (c << 1) ^ CRC_POLY;
            end
            else
            begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/rfrc_byte_if.sv =====
// ----------------------------------------------------------------------------
// rfrc_byte_if
// Received byte channel: one frame byte and its end marker per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfrc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== src/rfrc_result_if.sv =====
// ----------------------------------------------------------------------------
// rfrc_result_if
// Result channel: a payload byte or a frame status per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfrc_result_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [2:0] status;
    logic [7:0] source_id;
    logic [7:0] sequence_res;
    logic [7:0] payload_length;
    logic       ack_owed;

    modport source (output valid, output kind, output payload_byte, output status,
                    output source_id, output sequence_res, output payload_length,
                    output ack_owed, input ready);
    modport sink   (input valid, input kind, input payload_byte, input status,
                    input source_id, input sequence_res, input payload_length,
                    input ack_owed, output ready);
endinterface

`default_nettype wire

// ===== src/rfrc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rfrc_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfrc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/radio_frame_receive_check_unit.sv =====
// ----------------------------------------------------------------------------
// radio_frame_receive_check_unit
// Receive-side frame checker: header capture, CRC-16 check, payload copy.
// ----------------------------------------------------------------------------
// Results of a byte are written to the result queue; res offers the queue head.
// Throughput: one byte per cycle while rx.ready is high; the closing byte may
// yield two result beats, drained one per cycle while res.ready is high from a
// DEPTH-entry result queue. rx.ready is high while the queue has two free entries.
// Reset (async, active low) clears frame state and queue, restores register defaults.
`default_nettype none
`include "assert_macros.svh"

module radio_frame_receive_check_unit #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    rfrc_byte_if.sink     rx,
    rfrc_result_if.source res,
    rfrc_cfg_if.sink      cfg
);
    import rfrc_pkg::*;

    cfg_regs_t regs;
    push_t     push;
    logic      room;
    logic      rx_fire;

    assign rx.ready = room;
    assign rx_fire  = rx.valid && rx.ready;

    rfrc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    rfrc_frame_check u_frame_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (rx_fire),
        .rx_byte   (rx.rx_byte),
        .frame_end (rx.frame_end),
        .regs      (regs),
        .push      (push)
    );

    rfrc_result_fifo #(
        .DEPTH (DEPTH)
    ) u_result_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .res   (res)
    );

    `ASSERT_PROP(a_push_needs_beat, clk, rst_n, (push.num != PUSH_NONE) |-> rx_fire, "result pushed without an input beat")
    `ASSERT_PROP(a_two_only_at_end, clk, rst_n, (push.num == PUSH_TWO) |-> rx.frame_end, "two results from a byte that does not close the frame")
    `ASSERT_PROP(a_end_gives_status, clk, rst_n, (rx_fire && rx.frame_end) |-> (push.num != PUSH_NONE), "closing byte produced no status")
    `ASSERT_NEVER(a_stall_with_empty, clk, rst_n, !rx.ready && !res.valid, "input stalled while result queue is empty")

endmodule

`default_nettype wire

// ===== src/rfrc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rfrc_cfg_regs
// Configuration register file, always ready for a write beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrc_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    rfrc_cfg_if.sink           cfg,
    output rfrc_pkg::cfg_regs_t regs
);
    import rfrc_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_LOCAL_ID:     regs_next.local_id         = cfg.data;
                REG_BROADCAST_ID: regs_next.broadcast_id     = cfg.data;
                REG_ACK_MASK:     regs_next.ack_request_mask = cfg.data;
                REG_MAX_COPY:     regs_next.max_copy_len     = cfg.data;
                default:          regs_next                  = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.local_id         <= 8'd0;
            regs_reg.broadcast_id     <= 8'd255;
            regs_reg.ack_request_mask <= 8'd1;
            regs_reg.max_copy_len     <= 8'd255;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/rfrc_frame_check.sv =====
// ----------------------------------------------------------------------------
// rfrc_frame_check
// Per-frame state, CRC update, payload copy decision and status checks.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrc_frame_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  logic                frame_end,
    input  rfrc_pkg::cfg_regs_t regs,
    output rfrc_pkg::push_t     push
);
    import rfrc_pkg::*;

    logic [8:0]  index_reg,  index_next;
    logic [15:0] crc_reg,    crc_next;
    logic [15:0] crc_rx_reg, crc_rx_next;
    logic [7:0]  dest_reg,   dest_next;
    logic [7:0]  src_reg,    src_next;
    logic [7:0]  seq_reg,    seq_next;
    logic [7:0]  flags_reg,  flags_next;
    logic [7:0]  len_reg,    len_next;

    logic [7:0]  dest_cur, src_cur, seq_cur, flags_cur, len_cur;
    logic [15:0] crc_cur, crc_rx_cur;
    logic [8:0]  pay_idx, count_cur, len_total;
    logic        addr_ok, in_payload, copy_byte;
    logic [2:0]  status_cur;
    result_t     pay_res, stat_res;

    always_comb
    begin
        dest_cur  = (index_reg == IDX_DEST)  ? rx_byte : dest_reg;
        src_cur   = (index_reg == IDX_SRC)   ? rx_byte : src_reg;
        seq_cur   = (index_reg == IDX_SEQ)   ? rx_byte : seq_reg;
        flags_cur = (index_reg == IDX_FLAGS) ? rx_byte : flags_reg;
        len_cur   = (index_reg == IDX_LEN)   ? rx_byte : len_reg;

        addr_ok    = (dest_cur == regs.local_id) || (dest_cur == regs.broadcast_id);
        pay_idx    = index_reg - HDR_LEN;
        in_payload = (index_reg >= HDR_LEN) && (pay_idx < {1'b0, len_cur});
        crc_cur    = ((index_reg < HDR_LEN) || in_payload) ?
                     crc16_byte(crc_reg, rx_byte) : crc_reg;
        crc_rx_cur = {crc_rx_reg[7:0], rx_byte};
        copy_byte  = in_payload && (pay_idx < {1'b0, regs.max_copy_len}) && addr_ok;

        count_cur  = (index_reg != COUNT_MAX) ? index_reg + 9'd1 : index_reg;
        len_total  = {1'b0, len_cur} + MIN_FRAME;

        if (count_cur < MIN_FRAME)
        begin
            status_cur = STATUS_TOO_SHORT;
        end
        else if (!addr_ok)
        begin
            status_cur = STATUS_WRONG_ADDR;
        end
        else if (count_cur != len_total)
        begin
            status_cur = STATUS_LEN_ERR;
        end
        else if (crc_rx_cur != crc_cur)
        begin
            status_cur = STATUS_CRC_ERR;
        end
        else
        begin
            status_cur = STATUS_OK;
        end

        pay_res              = '0;
        pay_res.kind         = KIND_PAYLOAD;
        pay_res.payload_byte = rx_byte;

        stat_res                = '0;
        stat_res.kind           = KIND_STATUS;
        stat_res.status         = status_cur;
        stat_res.source_id      = src_cur;
        stat_res.sequence_res   = seq_cur;
        stat_res.payload_length = len_cur;
        stat_res.ack_owed       = (status_cur == STATUS_OK) &&
                                  (dest_cur == regs.local_id) &&
                                  ((flags_cur & regs.ack_request_mask) != 8'd0);

        push.first  = copy_byte ? pay_res : stat_res;
        push.second = stat_res;
        if (!accept)
        begin
            push.num = PUSH_NONE;
        end
        else if (copy_byte && frame_end)
        begin
            push.num = PUSH_TWO;
        end
        else if (copy_byte || frame_end)
        begin
            push.num = PUSH_ONE;
        end
        else
        begin
            push.num = PUSH_NONE;
        end
    end

    always_comb
    begin
        index_next  = index_reg;
        crc_next    = crc_reg;
        crc_rx_next = crc_rx_reg;
        dest_next   = dest_reg;
        src_next    = src_reg;
        seq_next    = seq_reg;
        flags_next  = flags_reg;
        len_next    = len_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                index_next  = 9'd0;
                crc_next    = CRC_INIT;
                crc_rx_next = 16'd0;
                dest_next   = 8'd0;
                src_next    = 8'd0;
                seq_next    = 8'd0;
                flags_next  = 8'd0;
                len_next    = 8'd0;
            end
            else
            begin
                index_next  = count_cur;
                crc_next    = crc_cur;
                crc_rx_next = crc_rx_cur;
                dest_next   = dest_cur;
                src_next    = src_cur;
                seq_next    = seq_cur;
                flags_next  = flags_cur;
                len_next    = len_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg  <= 9'd0;
            crc_reg    <= CRC_INIT;
            crc_rx_reg <= 16'd0;
            dest_reg   <= 8'd0;
            src_reg    <= 8'd0;
            seq_reg    <= 8'd0;
            flags_reg  <= 8'd0;
            len_reg    <= 8'd0;
        end
        else
        begin
            index_reg  <= index_next;
            crc_reg    <= crc_next;
            crc_rx_reg <= crc_rx_next;
            dest_reg   <= dest_next;
            src_reg    <= src_next;
            seq_reg    <= seq_next;
            flags_reg  <= flags_next;
            len_reg    <= len_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/rfrc_result_fifo.sv =====
// ----------------------------------------------------------------------------
// rfrc_result_fifo
// Result queue: up to two results in per cycle, one beat out per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrc_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rfrc_pkg::push_t push,
    output logic            room,
    rfrc_result_if.source   res
);
    import rfrc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, wr_ptr_plus1;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    result_t            head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign head         = mem[rd_ptr_reg];
    assign pop          = res.valid && res.ready;
    assign room         = (count_reg <= CNT_W'(DEPTH - 2));
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);

    assign res.valid          = (count_reg != '0);
    assign res.kind           = head.kind;
    assign res.payload_byte   = head.payload_byte;
    assign res.status         = head.status;
    assign res.source_id      = head.source_id;
    assign res.sequence_res   = head.sequence_res;
    assign res.payload_length = head.payload_length;
    assign res.ack_owed       = head.ack_owed;

    always_comb
    begin
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.num) - CNT_W'(pop);
        case (push.num)
            PUSH_ONE: wr_ptr_next = wr_ptr_plus1;
            PUSH_TWO: wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default:  wr_ptr_next = wr_ptr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push.num != PUSH_NONE)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == PUSH_TWO)
        begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radio frame receive checker. Frames are built
// with random headers, payloads and CRC trailers, plus short, over-long,
// misaddressed and corrupted ones. A local model of the checker predicts the
// payload and status beats of every accepted byte, and a monitor compares
// each result beat field by field. Register settings change between runs.
// ----------------------------------------------------------------------------

module tb;

    import rfrc_pkg::*;

    localparam int               STALL_LIMIT   = 4000;
    localparam logic [7:0]       REG_UNUSED_LO = REG_MAX_COPY + 8'd1;
    localparam logic [7:0]       REG_UNUSED_HI = 8'hFF;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rx_beat_t;

    logic clk = 1'b0;
    logic rst_n;

    rfrc_byte_if   rx_ch ();
    rfrc_result_if res_ch ();
    rfrc_cfg_if    cfg_ch ();

    radio_frame_receive_check_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    rx_beat_t pending_beats[$];
    result_t  expected_results[$];
    rx_beat_t nxt_beat;
    int       queued_beats;
    int       error_count;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_stall_pct;

    logic [7:0]  node_id;
    logic [7:0]  bcast_id;
    logic [7:0]  ack_mask;
    logic [7:0]  copy_cap;

    logic [8:0]  frm_count;
    logic [15:0] frm_crc;
    logic [15:0] frm_tail;
    logic [7:0]  frm_dest;
    logic [7:0]  frm_src;
    logic [7:0]  frm_seq;
    logic [7:0]  frm_flags;
    logic [7:0]  frm_len;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [15:0] crc_after_byte(input logic [15:0] crc,
                                                   input logic [7:0]  d);
        logic [15:0] c;
        logic        fb;
        int          i;
        c = crc;
        for (i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        frm_count = '0;
        frm_crc   = CRC_INIT;
        frm_tail  = '0;
        frm_dest  = '0;
        frm_src   = '0;
        frm_seq   = '0;
        frm_flags = '0;
        frm_len   = '0;
    endtask

    task automatic predict_rx_beat(input logic [7:0] b, input logic fin);
        logic [8:0] pos;
        logic [8:0] off;
        logic       addr_hit;
        logic       in_body;
        logic [2:0] st;
        result_t    r;
        pos = frm_count;
        case (pos)
            IDX_DEST:  frm_dest  = b;
            IDX_SRC:   frm_src   = b;
            IDX_SEQ:   frm_seq   = b;
            IDX_FLAGS: frm_flags = b;
            IDX_LEN:   frm_len   = b;
            default:   ;
        endcase
        addr_hit = (frm_dest == node_id) || (frm_dest == bcast_id);
        off      = pos - HDR_LEN;
        in_body  = (pos >= HDR_LEN) && (off < {1'b0, frm_len});
        if (pos < HDR_LEN || in_body)
        begin
            frm_crc = crc_after_byte(frm_crc, b);
        end
        frm_tail = {frm_tail[7:0], b};
        if (in_body && off < {1'b0, copy_cap} && addr_hit)
        begin
            r              = '0;
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            expected_results.push_back(r);
        end
        if (frm_count != COUNT_MAX)
        begin
            frm_count = frm_count + 9'd1;
        end
        if (fin)
        begin
            if (frm_count < MIN_FRAME)
                st = STATUS_TOO_SHORT;
            else if (!addr_hit)
                st = STATUS_WRONG_ADDR;
            else if (frm_count != ({1'b0, frm_len} + MIN_FRAME))
                st = STATUS_LEN_ERR;
            else if (frm_tail != frm_crc)
                st = STATUS_CRC_ERR;
            else
                st = STATUS_OK;
            r                = '0;
            r.kind           = KIND_STATUS;
            r.status         = st;
            r.source_id      = frm_src;
            r.sequence_res   = frm_seq;
            r.payload_length = frm_len;
            r.ack_owed       = (st == STATUS_OK) && (frm_dest == node_id) &&
                               ((frm_flags & ack_mask) != 8'h00);
            expected_results.push_back(r);
            clear_frame_state();
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    task automatic check_result_beat();
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result beat: kind %0d status %0d", res_ch.kind, res_ch.status);
            error_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            check_field("kind", want.kind, res_ch.kind);
            check_field("payload_byte", want.payload_byte, res_ch.payload_byte);
            check_field("status", want.status, res_ch.status);
            check_field("source_id", want.source_id, res_ch.source_id);
            check_field("sequence_res", want.sequence_res, res_ch.sequence_res);
            check_field("payload_length", want.payload_length, res_ch.payload_length);
            check_field("ack_owed", want.ack_owed, res_ch.ack_owed);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_ch.valid     <= 1'b0;
            rx_ch.rx_byte   <= 8'h00;
            rx_ch.frame_end <= 1'b0;
        end
        else
        begin
            if (rx_ch.valid && rx_ch.ready)
            begin
                predict_rx_beat(rx_ch.rx_byte, rx_ch.frame_end);
            end
            if (!rx_ch.valid || rx_ch.ready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt_beat         = pending_beats.pop_front();
                    rx_ch.valid     <= 1'b1;
                    rx_ch.rx_byte   <= nxt_beat.data;
                    rx_ch.frame_end <= nxt_beat.last;
                end
                else
                begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                check_result_beat();
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_LOCAL_ID:     node_id  = val;
            REG_BROADCAST_ID: bcast_id = val;
            REG_ACK_MASK:     ack_mask = val;
            REG_MAX_COPY:     copy_cap = val;
            default:          ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [7:0] loc, input logic [7:0] bc,
                                  input logic [7:0] mask, input logic [7:0] cap);
        write_reg(REG_LOCAL_ID, loc);
        write_reg(REG_BROADCAST_ID, bc);
        write_reg(REG_ACK_MASK, mask);
        write_reg(REG_MAX_COPY, cap);
    endtask

    task automatic wait_for_drain();
        while (pending_beats.size() != 0 || rx_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic push_beat(input logic [7:0] d, input logic last);
        rx_beat_t b;
        b.data = d;
        b.last = last;
        pending_beats.push_back(b);
        queued_beats++;
    endtask

    task automatic queue_frame(input logic [7:0] dest, input logic [7:0] flags,
                               input logic [7:0] len, input int body, input logic bad_crc);
        logic [7:0]  hdr [5];
        logic [15:0] crc;
        logic [7:0]  d;
        int          i;
        hdr[0] = dest;
        hdr[1] = 8'($urandom_range(255));
        hdr[2] = 8'($urandom_range(255));
        hdr[3] = flags;
        hdr[4] = len;
        crc    = CRC_INIT;
        for (i = 0; i < 5; i++)
        begin
            crc = crc_after_byte(crc, hdr[i]);
            push_beat(hdr[i], 1'b0);
        end
        for (i = 0; i < body; i++)
        begin
            d = 8'($urandom_range(255));
            if (i < int'(len))
            begin
                crc = crc_after_byte(crc, d);
            end
            push_beat(d, 1'b0);
        end
        if (bad_crc)
        begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        push_beat(crc[15:8], 1'b0);
        push_beat(crc[7:0], 1'b1);
    endtask

    task automatic queue_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
        begin
            push_beat(8'($urandom_range(255)), i == n - 1);
        end
    endtask

    function automatic logic [7:0] pick_dest();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return node_id;
        else if (r < 70)
            return bcast_id;
        else
            return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return 8'($urandom_range(12));
        else if (r < 97)
            return 8'($urandom_range(40, 13));
        else
            return 8'($urandom_range(80, 41));
    endfunction

    task automatic fill_random_frames(input int budget);
        int         start;
        int         r;
        int         body;
        logic [7:0] len;
        start = queued_beats;
        while (queued_beats - start < budget)
        begin
            r   = $urandom_range(99);
            len = pick_len();
            if (r < 66)
            begin
                queue_frame(pick_dest(), 8'($urandom_range(255)), len, int'(len), 1'b0);
            end
            else if (r < 74)
            begin
                queue_frame(pick_dest(), 8'($urandom_range(255)), len, int'(len), 1'b1);
            end
            else if (r < 82)
            begin
                if (len != 8'd0 && $urandom_range(1) == 1)
                    body = int'(len) - 1;
                else
                    body = int'(len) + int'($urandom_range(3, 1));
                queue_frame(pick_dest(), 8'($urandom_range(255)), len, body, 1'b0);
            end
            else if (r < 90)
            begin
                queue_noise(int'($urandom_range(6, 1)));
            end
            else
            begin
                queue_noise(int'($urandom_range(24, 7)));
            end
        end
    endtask

    initial
    begin
        int         p;
        logic [7:0] shared_id;

        rst_n           = 1'b0;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = 8'h00;
        rx_ch.frame_end = 1'b0;
        res_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = 8'h00;
        cfg_ch.data     = 8'h00;
        queued_beats    = 0;
        error_count     = 0;
        idle_cycles     = 0;
        send_idle_pct   = 27;
        recv_stall_pct  = 46;
        node_id         = 8'd0;
        bcast_id        = 8'd255;
        ack_mask        = 8'd1;
        copy_cap        = 8'd255;
        clear_frame_state();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        queue_frame(8'h00, 8'h01, 8'd0, 0, 1'b0);
        queue_frame(8'hFF, 8'hFF, 8'd1, 1, 1'b0);
        queue_frame(8'h5A, 8'h01, 8'd0, 0, 1'b0);
        queue_noise(1);
        queue_frame(8'h00, 8'h01, 8'd1, 2, 1'b0);
        queue_frame(8'h00, 8'h01, 8'd0, 0, 1'b1);
        wait_for_drain();

        for (p = 1; p <= 6; p++)
        begin
            if (p <= 2)
            begin
                send_idle_pct  = 27;
                recv_stall_pct = 46;
            end
            else if (p <= 4)
            begin
                send_idle_pct  = 46;
                recv_stall_pct = 27;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (p)
                1: write_all_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255, 1)), 8'($urandom_range(8, 1)));
                2: write_all_regs(8'd255, 8'd0, 8'd255, 8'd0);
                3:
                begin
                    shared_id = 8'($urandom_range(255));
                    write_all_regs(shared_id, shared_id, 8'h01 << $urandom_range(7), 8'd255);
                end
                4:
                begin
                    write_all_regs(8'd0, 8'd255, 8'd128, 8'd255);
                    write_reg(REG_UNUSED_LO, 8'($urandom_range(255)));
                    write_reg(REG_UNUSED_HI, 8'($urandom_range(255)));
                end
                5: write_all_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255, 1)), 8'($urandom_range(255)));
                default: write_all_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                                        8'd1, 8'($urandom_range(20)));
            endcase
            if (p == 3)
            begin
                queue_frame(node_id, 8'($urandom_range(255)), 8'd255, 3, 1'b0);
                queue_frame(node_id, 8'($urandom_range(255)), 8'($urandom_range(255)),
                            505, 1'b0);
            end
            fill_random_frames(45);
            wait_for_drain();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/rfrc_pkg.sv
src/rfrc_byte_if.sv
src/rfrc_result_if.sv
src/rfrc_cfg_if.sv
src/rfrc_cfg_regs.sv
src/rfrc_frame_check.sv
src/rfrc_result_fifo.sv
src/radio_frame_receive_check_unit.sv
bench/tb.sv
